@@ sv/ssjf_pkg.sv @@
// Shared types, constants and helper functions for the servo slew and joint feedback block.
// No dependencies; every other file refers to it by scoped names.
package ssjf_pkg;

    localparam int DEF_ADC_BITS        = 12;
    localparam int DEF_NUM_SLEW_JOINTS = 5;

    localparam int ANGLE_W    = 12;
    localparam int INTERVAL_W = 16;
    localparam int DEG_CFG_W  = 9;
    localparam int MV_CFG_W   = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SAMPLE_W   = 12;

    // Feedback divider: signed product magnitude over map angle span
    localparam int DIV_NUM_W = 25;
    localparam int DIV_DEN_W = 9;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_ADC  = 2'd2;

    localparam logic [1:0] DRV_STOP  = 2'd0;
    localparam logic [1:0] DRV_LEFT  = 2'd1;
    localparam logic [1:0] DRV_RIGHT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MV_MIN        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MV_MAX        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MV        = 3'd6;

    localparam logic [INTERVAL_W-1:0] MOVE_INTERVAL_RST = 16'd20;
    localparam logic [DEG_CFG_W-1:0]  ANGLE_MIN_RST     = 9'd0;
    localparam logic [DEG_CFG_W-1:0]  ANGLE_MAX_RST     = 9'd270;
    localparam logic [MV_CFG_W-1:0]   MV_MIN_RST        = 13'd0;
    localparam logic [MV_CFG_W-1:0]   MV_MAX_RST        = 13'd3300;
    localparam logic [MV_CFG_W-1:0]   TOLERANCE_RST     = 13'd50;
    localparam logic [MV_CFG_W-1:0]   REF_MV_RST        = 13'd3300;

    localparam logic [15:0] RECIP_10 = 16'hCCCD;
    localparam logic [15:0] RECIP_15 = 16'h8889;
    localparam logic [ANGLE_W-1:0] LIMIT_WIDE   = 12'd2700;
    localparam logic [ANGLE_W-1:0] LIMIT_NARROW = 12'd1800;

    typedef struct packed {
        logic [1:0]          command;
        logic [2:0]          joint;
        logic [ANGLE_W-1:0]  target_tenths;
        logic [SAMPLE_W-1:0] adc_sample;
    } in_item_t;

    typedef struct packed {
        logic [2:0] joint_out;
        logic [7:0] servo_angle;
        logic [1:0] drive_code;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [DEG_CFG_W-1:0] angle_min;
        logic [DEG_CFG_W-1:0] angle_max;
        logic [MV_CFG_W-1:0]  mv_min;
        logic [MV_CFG_W-1:0]  mv_max;
        logic [MV_CFG_W-1:0]  tolerance;
        logic [MV_CFG_W-1:0]  ref_mv;
    } fb_cfg_t;

    // Power-up angle of slewed joint idx+1
    function automatic logic [ANGLE_W-1:0] cur_reset(input logic [3:0] idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            4'd0, 4'd1: v = 12'd1300;
            4'd2, 4'd3: v = 12'd800;
            4'd4:       v = 12'd900;
            default:    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [ANGLE_W-1:0] tgt_reset(input logic [3:0] idx);
        logic [ANGLE_W-1:0] v;
        if (idx == 4'd0) begin
            v = '0;
        end else begin
            v = cur_reset(idx - 4'd1);
        end
        return v;
    endfunction

    // Exact x/10 for 12-bit x
    function automatic logic [8:0] div10(input logic [ANGLE_W-1:0] x);
        logic [27:0] p;
        p = x * RECIP_10;
        return p[27:19];
    endfunction

    // Exact x/15 for x up to 2700
    function automatic logic [7:0] div15(input logic [ANGLE_W-1:0] x);
        logic [27:0] p;
        p = x * RECIP_15;
        return p[26:19];
    endfunction

    function automatic logic [7:0] servo_deg(input logic [3:0] joint,
                                             input logic [ANGLE_W-1:0] tenths);
        logic [ANGLE_W-1:0] t;
        logic [8:0]         d;
        logic [7:0]         r;
        if (joint == 4'd1 || joint == 4'd2) begin
            t = (tenths > LIMIT_WIDE) ? LIMIT_WIDE : tenths;
            r = div15(t);
        end else begin
            t = (tenths > LIMIT_NARROW) ? LIMIT_NARROW : tenths;
            d = div10(t);
            r = d[7:0];
        end
        return r;
    endfunction

endpackage

@@ sv/ssjf_ram.sv @@
// Generic single-write, single-read RAM with registered read.
// Depends on ssjf_pkg for default sizes.
module ssjf_ram #(
    parameter int WIDTH = ssjf_pkg::ANGLE_W,
    parameter int DEPTH = ssjf_pkg::DEF_NUM_SLEW_JOINTS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/ssjf_div.sv @@
// Bit-serial restoring divider on unsigned magnitudes, one quotient bit per cycle.
// Depends on ssjf_pkg for default widths.
module ssjf_div #(
    parameter int NW = ssjf_pkg::DIV_NUM_W,
    parameter int DW = ssjf_pkg::DIV_DEN_W
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quot_reg, quot_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quot_reg[NW-1]};
        if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next  = DW'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[NW-2:0], 1'b1};
            end else begin
                rem_next  = trial[DW-1:0];
                quot_next = {quot_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ sv/ssjf_feedback.sv @@
// Joint zero feedback: maps target degrees to millivolts and compares with the ADC sample.
// Depends on ssjf_pkg and ssjf_div.
module ssjf_feedback #(
    parameter int ADC_BITS = ssjf_pkg::DEF_ADC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [ssjf_pkg::ANGLE_W-1:0]      target0,
    input  logic [ssjf_pkg::SAMPLE_W-1:0]     sample,
    input  ssjf_pkg::fb_cfg_t                 cfg,
    output logic                              done,
    output logic [1:0]                        code
);

    localparam int NUM_W = ssjf_pkg::DIV_NUM_W;
    localparam int DEN_W = ssjf_pkg::DIV_DEN_W;
    localparam int MV_W  = NUM_W + 1;
    localparam int P1_W  = MV_W + ADC_BITS + 1;
    localparam int P2_W  = ssjf_pkg::SAMPLE_W + ssjf_pkg::MV_CFG_W;
    localparam int TFS_W = ssjf_pkg::MV_CFG_W + ADC_BITS;
    localparam int ERR_W = P1_W + 1;
    localparam logic [ADC_BITS-1:0] FS = '1;

    typedef enum logic [2:0] {
        F_IDLE, F_NUM, F_DIVGO, F_DIV, F_MV, F_MUL, F_ERR, F_CMP
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [8:0]                        deg_reg, deg_next;
    logic [ssjf_pkg::SAMPLE_W-1:0]     sample_reg, sample_next;
    logic signed [NUM_W-1:0]           num_reg, num_next;
    logic signed [DEN_W:0]             den_reg, den_next;
    logic                              neg_reg, neg_next;
    logic signed [NUM_W-1:0]           q_reg, q_next;
    logic signed [MV_W-1:0]            mv_reg, mv_next;
    logic signed [P1_W-1:0]            p1_reg, p1_next;
    logic [P2_W-1:0]                   p2_reg, p2_next;
    logic [TFS_W-1:0]                  tfs_reg, tfs_next;
    logic signed [ERR_W-1:0]           err_reg, err_next;
    logic                              done_reg, done_next;
    logic [1:0]                        code_reg, code_next;

    logic signed [10:0]                da;
    logic signed [13:0]                dm;
    logic signed [NUM_W-1:0]           prod;
    logic signed [DEN_W:0]             den_abs;
    logic [NUM_W-1:0]                  num_abs;
    logic                              div_start;
    logic                              div_done;
    logic [NUM_W-1:0]                  div_quot;
    logic [ERR_W-1:0]                  err_mag;

    ssjf_div #(
        .NW(NUM_W),
        .DW(DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_abs),
        .den     (den_abs[DEN_W-1:0]),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        state_next  = state_reg;
        deg_next    = deg_reg;
        sample_next = sample_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;
        q_next      = q_reg;
        mv_next     = mv_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        tfs_next    = tfs_reg;
        err_next    = err_reg;
        done_next   = 1'b0;
        code_next   = code_reg;
        div_start   = 1'b0;

        da      = $signed({2'b00, deg_reg}) - $signed({2'b00, cfg.angle_min});
        dm      = $signed({1'b0, cfg.mv_max}) - $signed({1'b0, cfg.mv_min});
        prod    = da * dm;
        num_abs = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        den_abs = den_reg[DEN_W] ? -den_reg : den_reg;
        err_mag = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);

        unique case (state_reg)
            F_IDLE: begin
                if (start) begin
                    deg_next    = ssjf_pkg::div10(target0);
                    sample_next = sample;
                    state_next  = F_NUM;
                end
            end
            F_NUM: begin
                num_next   = prod;
                den_next   = $signed({1'b0, cfg.angle_max}) - $signed({1'b0, cfg.angle_min});
                state_next = F_DIVGO;
            end
            F_DIVGO: begin
                if (den_reg == '0) begin
                    q_next     = '0;
                    state_next = F_MV;
                end else begin
                    neg_next   = num_reg[NUM_W-1] ^ den_reg[DEN_W];
                    div_start  = 1'b1;
                    state_next = F_DIV;
                end
            end
            F_DIV: begin
                if (div_done) begin
                    q_next     = neg_reg ? -$signed(div_quot) : $signed(div_quot);
                    state_next = F_MV;
                end
            end
            F_MV: begin
                mv_next    = $signed({q_reg[NUM_W-1], q_reg})
                           + $signed({{(MV_W - ssjf_pkg::MV_CFG_W){1'b0}}, cfg.mv_min});
                state_next = F_MUL;
            end
            F_MUL: begin
                p1_next    = mv_reg * $signed({1'b0, FS});
                p2_next    = sample_reg * cfg.ref_mv;
                tfs_next   = cfg.tolerance * FS;
                state_next = F_ERR;
            end
            F_ERR: begin
                err_next   = $signed({p1_reg[P1_W-1], p1_reg})
                           - $signed({{(ERR_W - P2_W){1'b0}}, p2_reg});
                state_next = F_CMP;
            end
            F_CMP: begin
                if (err_mag <= {{(ERR_W - TFS_W){1'b0}}, tfs_reg}) begin
                    code_next = ssjf_pkg::DRV_STOP;
                end else if (!err_reg[ERR_W-1]) begin
                    code_next = ssjf_pkg::DRV_LEFT;
                end else begin
                    code_next = ssjf_pkg::DRV_RIGHT;
                end
                done_next  = 1'b1;
                state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        deg_reg    <= deg_next;
        sample_reg <= sample_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        q_reg      <= q_next;
        mv_reg     <= mv_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        tfs_reg    <= tfs_next;
        err_reg    <= err_next;
        code_reg   <= code_next;
    end

    assign done = done_reg;
    assign code = code_reg;

endmodule

@@ sv/servo_slew_and_joint_feedback_top.sv @@
// Top level of the servo slew and joint feedback block: sequencer, state RAMs, output stage.
// Depends on ssjf_pkg, ssjf_ram and ssjf_feedback.

// Six-joint servo controller. Joint angles live in two 12-bit RAMs (current angles of the
// slewed joints, targets of all joints) with valid bits, so reset values apply at once and
// there is no clearing pass. A set-target transfer is handled in the idle state, as is a
// tick that is not yet due. A due tick reads each slewed joint's current and target angle,
// steps it one tenth towards target and writes it back, one joint per cycle through the
// single RAM read port while the output register is free, with results emitted as joints
// 3 and up, then 1, then 2, last marked on the final one. An ADC sample runs through the
// 25-bit bit-serial divider of the angle to millivolt map. The next input is taken while
// a result still waits in the output register.
module servo_slew_and_joint_feedback_top #(
    parameter int ADC_BITS        = ssjf_pkg::DEF_ADC_BITS,
    parameter int NUM_SLEW_JOINTS = ssjf_pkg::DEF_NUM_SLEW_JOINTS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ssjf_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ssjf_pkg::out_item_t                m_data,
    input  logic                               cfg_we,
    input  logic [ssjf_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [ssjf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int N      = NUM_SLEW_JOINTS;
    localparam int AW     = ssjf_pkg::ANGLE_W;
    localparam int CUR_AW = (N > 1) ? $clog2(N) : 1;
    localparam int TGT_AW = $clog2(N + 1);
    localparam int FRONT  = (N >= 3) ? N - 2 : 0;
    localparam bit EMIT   = (N >= 2);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SLEW, ST_FB_START, ST_FB_RUN, ST_FB_OUT
    } state_t;

    function automatic logic [3:0] joint_of(input logic [CUR_AW-1:0] k);
        logic [3:0] j;
        if (int'(k) < FRONT) begin
            j = 4'(int'(k) + 3);
        end else begin
            j = 4'(int'(k) - FRONT + 1);
        end
        return j;
    endfunction

    state_t                              state_reg, state_next;
    logic [CUR_AW-1:0]                   k_reg, k_next;
    logic [ssjf_pkg::INTERVAL_W-1:0]     cnt_reg, cnt_next;
    logic [ssjf_pkg::INTERVAL_W-1:0]     interval_reg, interval_next;
    ssjf_pkg::fb_cfg_t                   fbcfg_reg, fbcfg_next;
    logic [N-1:0]                        cur_vld_reg, cur_vld_next;
    logic [N:0]                          tgt_vld_reg, tgt_vld_next;
    logic [ssjf_pkg::SAMPLE_W-1:0]       sample_reg, sample_next;
    logic [1:0]                          code_reg, code_next;
    logic                                m_valid_reg, m_valid_next;
    ssjf_pkg::out_item_t                 out_reg, out_next;

    logic                                cur_we, cur_re;
    logic [CUR_AW-1:0]                   cur_waddr, cur_raddr;
    logic [AW-1:0]                       cur_wdata, cur_rdata;
    logic                                tgt_we, tgt_re;
    logic [TGT_AW-1:0]                   tgt_waddr, tgt_raddr;
    logic [AW-1:0]                       tgt_wdata, tgt_rdata;

    logic                                fb_start, fb_done;
    logic [1:0]                          fb_code;
    logic [AW-1:0]                       fb_target;

    logic                                s_accept, out_free, k_last;
    logic [3:0]                          slew_joint;
    logic [CUR_AW-1:0]                   cur_addr_k;
    logic [TGT_AW-1:0]                   tgt_addr_k;
    logic [AW-1:0]                       cur_now, tgt_now, cur_new;
    logic [ssjf_pkg::INTERVAL_W-1:0]     cnt_inc;

    ssjf_ram #(
        .WIDTH(AW),
        .DEPTH(N),
        .AW   (CUR_AW)
    ) u_cur_ram (
        .aclk    (aclk),
        .wr_en   (cur_we),
        .wr_addr (cur_waddr),
        .wr_data (cur_wdata),
        .rd_en   (cur_re),
        .rd_addr (cur_raddr),
        .rd_data (cur_rdata)
    );

    ssjf_ram #(
        .WIDTH(AW),
        .DEPTH(N + 1),
        .AW   (TGT_AW)
    ) u_tgt_ram (
        .aclk    (aclk),
        .wr_en   (tgt_we),
        .wr_addr (tgt_waddr),
        .wr_data (tgt_wdata),
        .rd_en   (tgt_re),
        .rd_addr (tgt_raddr),
        .rd_data (tgt_rdata)
    );

    ssjf_feedback #(
        .ADC_BITS(ADC_BITS)
    ) u_feedback (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fb_start),
        .target0 (fb_target),
        .sample  (sample_reg),
        .cfg     (fbcfg_reg),
        .done    (fb_done),
        .code    (fb_code)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign slew_joint = joint_of(k_reg);
    assign cur_addr_k = CUR_AW'(slew_joint - 4'd1);
    assign tgt_addr_k = TGT_AW'(slew_joint);
    assign k_last     = (int'(k_reg) == N - 1);
    assign cnt_inc    = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;

    assign cur_now   = cur_vld_reg[cur_addr_k] ? cur_rdata
                                               : ssjf_pkg::cur_reset(slew_joint - 4'd1);
    assign tgt_now   = tgt_vld_reg[tgt_addr_k] ? tgt_rdata : ssjf_pkg::tgt_reset(slew_joint);
    assign fb_target = tgt_vld_reg[0] ? tgt_rdata : ssjf_pkg::tgt_reset(4'd0);

    always_comb begin
        if (cur_now < tgt_now) begin
            cur_new = cur_now + 1'b1;
        end else if (cur_now > tgt_now) begin
            cur_new = cur_now - 1'b1;
        end else begin
            cur_new = cur_now;
        end
    end

    always_comb begin
        interval_next = interval_reg;
        fbcfg_next    = fbcfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                ssjf_pkg::CFG_MOVE_INTERVAL: interval_next = cfg_wdata;
                ssjf_pkg::CFG_ANGLE_MIN: fbcfg_next.angle_min = cfg_wdata[8:0];
                ssjf_pkg::CFG_ANGLE_MAX: fbcfg_next.angle_max = cfg_wdata[8:0];
                ssjf_pkg::CFG_MV_MIN:    fbcfg_next.mv_min    = cfg_wdata[12:0];
                ssjf_pkg::CFG_MV_MAX:    fbcfg_next.mv_max    = cfg_wdata[12:0];
                ssjf_pkg::CFG_TOLERANCE: fbcfg_next.tolerance = cfg_wdata[12:0];
                ssjf_pkg::CFG_REF_MV:    fbcfg_next.ref_mv    = cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        cnt_next     = cnt_reg;
        cur_vld_next = cur_vld_reg;
        tgt_vld_next = tgt_vld_reg;
        sample_next  = sample_reg;
        code_next    = code_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        cur_we       = 1'b0;
        cur_waddr    = cur_addr_k;
        cur_wdata    = cur_new;
        cur_re       = 1'b0;
        cur_raddr    = CUR_AW'(joint_of('0) - 4'd1);
        tgt_we       = 1'b0;
        tgt_waddr    = TGT_AW'(s_data.joint);
        tgt_wdata    = s_data.target_tenths;
        tgt_re       = 1'b0;
        tgt_raddr    = TGT_AW'(joint_of('0));
        fb_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_data.command)
                        ssjf_pkg::CMD_TICK: begin
                            if (cnt_inc < interval_reg) begin
                                cnt_next = cnt_inc;
                            end else begin
                                cnt_next   = '0;
                                k_next     = '0;
                                cur_re     = 1'b1;
                                tgt_re     = 1'b1;
                                state_next = ST_SLEW;
                            end
                        end
                        ssjf_pkg::CMD_SET: begin
                            if (int'(s_data.joint) <= N) begin
                                tgt_we = 1'b1;
                                tgt_vld_next[TGT_AW'(s_data.joint)] = 1'b1;
                            end
                        end
                        ssjf_pkg::CMD_ADC: begin
                            tgt_re      = 1'b1;
                            tgt_raddr   = '0;
                            sample_next = s_data.adc_sample;
                            state_next  = ST_FB_START;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SLEW: begin
                if (!EMIT || out_free) begin
                    cur_we                   = 1'b1;
                    cur_vld_next[cur_addr_k] = 1'b1;
                    if (EMIT) begin
                        m_valid_next         = 1'b1;
                        out_next.joint_out   = 3'(slew_joint);
                        out_next.servo_angle = ssjf_pkg::servo_deg(slew_joint, cur_new);
                        out_next.drive_code  = ssjf_pkg::DRV_STOP;
                        out_next.last        = k_last;
                    end
                    if (k_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next    = k_reg + 1'b1;
                        cur_re    = 1'b1;
                        tgt_re    = 1'b1;
                        cur_raddr = CUR_AW'(joint_of(CUR_AW'(k_reg + 1'b1)) - 4'd1);
                        tgt_raddr = TGT_AW'(joint_of(CUR_AW'(k_reg + 1'b1)));
                    end
                end
            end
            ST_FB_START: begin
                fb_start   = 1'b1;
                state_next = ST_FB_RUN;
            end
            ST_FB_RUN: begin
                if (fb_done) begin
                    code_next  = fb_code;
                    state_next = ST_FB_OUT;
                end
            end
            ST_FB_OUT: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    out_next.joint_out   = 3'd0;
                    out_next.servo_angle = 8'd0;
                    out_next.drive_code  = code_reg;
                    out_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg              <= ST_IDLE;
            k_reg                  <= '0;
            cnt_reg                <= '0;
            interval_reg           <= ssjf_pkg::MOVE_INTERVAL_RST;
            fbcfg_reg.angle_min    <= ssjf_pkg::ANGLE_MIN_RST;
            fbcfg_reg.angle_max    <= ssjf_pkg::ANGLE_MAX_RST;
            fbcfg_reg.mv_min       <= ssjf_pkg::MV_MIN_RST;
            fbcfg_reg.mv_max       <= ssjf_pkg::MV_MAX_RST;
            fbcfg_reg.tolerance    <= ssjf_pkg::TOLERANCE_RST;
            fbcfg_reg.ref_mv       <= ssjf_pkg::REF_MV_RST;
            cur_vld_reg            <= '0;
            tgt_vld_reg            <= '0;
            m_valid_reg            <= 1'b0;
        end else begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            cnt_reg      <= cnt_next;
            interval_reg <= interval_next;
            fbcfg_reg    <= fbcfg_next;
            cur_vld_reg  <= cur_vld_next;
            tgt_vld_reg  <= tgt_vld_next;
            m_valid_reg  <= m_valid_next;
        end
        sample_reg <= sample_next;
        code_reg   <= code_next;
        out_reg    <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ tb/sv/servo_feedback_checker.sv @@
// Checker for the servo slew and joint feedback block: watches the input, result and register
// ports, predicts every result and compares it field by field. Depends on ssjf_pkg.
module servo_feedback_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  ssjf_pkg::in_item_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  ssjf_pkg::out_item_t             m_data,
    input  logic                            cfg_we,
    input  logic [ssjf_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [ssjf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              mismatch_count,
    output int                              outputs_owed
);

    localparam int    SLEW_JOINTS = ssjf_pkg::DEF_NUM_SLEW_JOINTS;
    localparam longint ADC_FULL   = (longint'(1) << ssjf_pkg::DEF_ADC_BITS) - 1;
    localparam logic [ssjf_pkg::ANGLE_W-1:0] POWER_UP [1:5] = '{12'd1300, 12'd1300, 12'd800,
                                                                12'd800, 12'd900};

    logic [ssjf_pkg::ANGLE_W-1:0]    cur_ang [1:SLEW_JOINTS];
    logic [ssjf_pkg::ANGLE_W-1:0]    tgt_ang [0:SLEW_JOINTS];
    logic [ssjf_pkg::INTERVAL_W-1:0] tick_count;

    logic [ssjf_pkg::INTERVAL_W-1:0] interval_reg;
    logic [ssjf_pkg::DEG_CFG_W-1:0]  amin_reg, amax_reg;
    logic [ssjf_pkg::MV_CFG_W-1:0]   mvlo_reg, mvhi_reg, tol_reg, refmv_reg;

    ssjf_pkg::out_item_t due_outputs [$];

    function automatic logic [7:0] servo_degrees(input int j,
                                                 input logic [ssjf_pkg::ANGLE_W-1:0] tenths);
        logic [ssjf_pkg::ANGLE_W-1:0] t;
        logic [ssjf_pkg::ANGLE_W-1:0] q;
        if (j == 1 || j == 2) begin
            t = (tenths > 12'd2700) ? 12'd2700 : tenths;
            q = t / 15;
        end else begin
            t = (tenths > 12'd1800) ? 12'd1800 : tenths;
            q = t / 10;
        end
        return q[7:0];
    endfunction

    // Bang-bang decision, scaled by full scale so no division is lost on the sample side
    function automatic ssjf_pkg::out_item_t feedback_drive(
        input logic [ssjf_pkg::SAMPLE_W-1:0] sample);
        longint deg, amin, amax, mvlo, mvhi, den, mv, err, tol, refmv, smp;
        ssjf_pkg::out_item_t r;
        deg   = tgt_ang[0] / 10;
        amin  = amin_reg;
        amax  = amax_reg;
        mvlo  = mvlo_reg;
        mvhi  = mvhi_reg;
        tol   = tol_reg;
        refmv = refmv_reg;
        smp   = sample;
        den   = amax - amin;
        mv    = mvlo;
        if (den != 0) begin
            mv = (deg - amin) * (mvhi - mvlo) / den + mvlo;
        end
        err = mv * ADC_FULL - smp * refmv;
        r.joint_out   = '0;
        r.servo_angle = '0;
        r.last        = 1'b1;
        if ((err < 0 ? -err : err) <= tol * ADC_FULL) begin
            r.drive_code = ssjf_pkg::DRV_STOP;
        end else if (err > 0) begin
            r.drive_code = ssjf_pkg::DRV_LEFT;
        end else begin
            r.drive_code = ssjf_pkg::DRV_RIGHT;
        end
        return r;
    endfunction

    task automatic slew_tick();
        ssjf_pkg::out_item_t r;
        int                  j;
        if (tick_count != 16'hFFFF) begin
            tick_count++;
        end
        if (tick_count >= interval_reg) begin
            tick_count = '0;
            for (j = 1; j <= SLEW_JOINTS; j++) begin
                if (cur_ang[j] < tgt_ang[j]) begin
                    cur_ang[j]++;
                end else if (cur_ang[j] > tgt_ang[j]) begin
                    cur_ang[j]--;
                end
            end
            // joints 3 and up first, then 1 and 2
            for (int k = 0; k < SLEW_JOINTS; k++) begin
                j = (k + 2) % SLEW_JOINTS + 1;
                r.joint_out   = 3'(j);
                r.servo_angle = servo_degrees(j, cur_ang[j]);
                r.drive_code  = ssjf_pkg::DRV_STOP;
                r.last        = (k == SLEW_JOINTS - 1);
                due_outputs.push_back(r);
            end
        end
    endtask

    task automatic take_item(input ssjf_pkg::in_item_t it);
        case (it.command)
            ssjf_pkg::CMD_SET: begin
                if (it.joint <= SLEW_JOINTS) begin
                    tgt_ang[it.joint] = it.target_tenths;
                end
            end
            ssjf_pkg::CMD_TICK: begin
                slew_tick();
            end
            ssjf_pkg::CMD_ADC: begin
                due_outputs.push_back(feedback_drive(it.adc_sample));
            end
            default: ;
        endcase
    endtask

    task automatic write_reg(input logic [ssjf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ssjf_pkg::CFG_DATA_W-1:0] v);
        case (idx)
            ssjf_pkg::CFG_MOVE_INTERVAL: interval_reg = v;
            ssjf_pkg::CFG_ANGLE_MIN:     amin_reg     = v[ssjf_pkg::DEG_CFG_W-1:0];
            ssjf_pkg::CFG_ANGLE_MAX:     amax_reg     = v[ssjf_pkg::DEG_CFG_W-1:0];
            ssjf_pkg::CFG_MV_MIN:        mvlo_reg     = v[ssjf_pkg::MV_CFG_W-1:0];
            ssjf_pkg::CFG_MV_MAX:        mvhi_reg     = v[ssjf_pkg::MV_CFG_W-1:0];
            ssjf_pkg::CFG_TOLERANCE:     tol_reg      = v[ssjf_pkg::MV_CFG_W-1:0];
            ssjf_pkg::CFG_REF_MV:        refmv_reg    = v[ssjf_pkg::MV_CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_output(input ssjf_pkg::out_item_t got);
        ssjf_pkg::out_item_t want;
        if (due_outputs.size() == 0) begin
            $error("unexpected result: joint_out %0d servo_angle %0d drive_code %0d last %0d",
                   got.joint_out, got.servo_angle, got.drive_code, got.last);
            mismatch_count++;
        end else begin
            want = due_outputs.pop_front();
            if (got.joint_out !== want.joint_out) begin
                $error("joint_out: expected %0d, got %0d", want.joint_out, got.joint_out);
                mismatch_count++;
            end
            if (got.servo_angle !== want.servo_angle) begin
                $error("servo_angle: expected %0d, got %0d", want.servo_angle, got.servo_angle);
                mismatch_count++;
            end
            if (got.drive_code !== want.drive_code) begin
                $error("drive_code: expected %0d, got %0d", want.drive_code, got.drive_code);
                mismatch_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 1; j <= SLEW_JOINTS; j++) begin
                cur_ang[j] = POWER_UP[j];
                tgt_ang[j] = POWER_UP[j];
            end
            tgt_ang[0]   = '0;
            tick_count   = '0;
            interval_reg = 16'd20;
            amin_reg     = 9'd0;
            amax_reg     = 9'd270;
            mvlo_reg     = 13'd0;
            mvhi_reg     = 13'd3300;
            tol_reg      = 13'd50;
            refmv_reg    = 13'd3300;
            due_outputs.delete();
            outputs_owed <= 0;
        end else begin
            if (cfg_we) begin
                write_reg(cfg_addr, cfg_wdata);
            end
            // compare before predicting, so a stray result never pairs with a fresh entry
            if (m_valid && m_ready) begin
                check_output(m_data);
            end
            if (s_valid && s_ready) begin
                take_item(s_data);
            end
            outputs_owed <= due_outputs.size();
        end
    end

endmodule

@@ tb/sv/servo_slew_and_joint_feedback_top_tb.sv @@
// Testbench top for the servo slew and joint feedback block: clock, reset, register writes,
// directed and random input transfers, result back-pressure and the verdict.
// Depends on ssjf_pkg, servo_slew_and_joint_feedback_top and servo_feedback_checker.
module servo_slew_and_joint_feedback_top_tb;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         SETTLE_CYCLES = 50;
    localparam int         ITEMS_PER_PHASE = 21;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    ssjf_pkg::in_item_t              s_data;
    logic                            m_valid;
    logic                            m_ready;
    ssjf_pkg::out_item_t             m_data;
    logic                            cfg_we;
    logic [ssjf_pkg::CFG_IDX_W-1:0]  cfg_addr;
    logic [ssjf_pkg::CFG_DATA_W-1:0] cfg_wdata;

    int   mismatch_count;
    int   outputs_owed;
    int   cycles;
    logic no_idle;

    servo_slew_and_joint_feedback_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    servo_feedback_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .mismatch_count(mismatch_count),
        .outputs_owed  (outputs_owed)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 6);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [2:0] jnt,
                             input logic [ssjf_pkg::ANGLE_W-1:0] tgt,
                             input logic [ssjf_pkg::SAMPLE_W-1:0] smp);
        ssjf_pkg::in_item_t it;
        it.command       = cmd;
        it.joint         = jnt;
        it.target_tenths = tgt;
        it.adc_sample    = smp;
        if (!no_idle && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_random();
        int                           pick;
        logic [1:0]                   cmd;
        logic [2:0]                   jnt;
        logic [ssjf_pkg::ANGLE_W-1:0] tgt;
        pick = $urandom_range(99);
        if (pick < 45) begin
            cmd = ssjf_pkg::CMD_TICK;
        end else if (pick < 75) begin
            cmd = ssjf_pkg::CMD_SET;
        end else if (pick < 94) begin
            cmd = ssjf_pkg::CMD_ADC;
        end else begin
            cmd = CMD_SPARE;
        end
        jnt = ($urandom_range(9) < 8) ? 3'($urandom_range(5)) : 3'($urandom_range(7));
        case ($urandom_range(3))
            0:       tgt = 12'($urandom_range(4095));
            1:       tgt = 12'($urandom_range(2700));
            // close to where the joints sit, so targets get reached
            default: tgt = 12'(($urandom_range(1) ? 1300 : 850) - 8 + $urandom_range(16));
        endcase
        send_item(cmd, jnt, tgt, 12'($urandom_range(4095)));
    endtask

    // Wait for every owed result, then for the longest busy spell of a result-free item
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outputs_owed != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ssjf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ssjf_pkg::CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
    endtask

    task automatic write_settings(input logic [15:0] interval, input logic [15:0] amin,
                                  input logic [15:0] amax, input logic [15:0] mvlo,
                                  input logic [15:0] mvhi, input logic [15:0] tol,
                                  input logic [15:0] refmv);
        write_reg(ssjf_pkg::CFG_MOVE_INTERVAL, interval);
        write_reg(ssjf_pkg::CFG_ANGLE_MIN, amin);
        write_reg(ssjf_pkg::CFG_ANGLE_MAX, amax);
        write_reg(ssjf_pkg::CFG_MV_MIN, mvlo);
        write_reg(ssjf_pkg::CFG_MV_MAX, mvhi);
        write_reg(ssjf_pkg::CFG_TOLERANCE, tol);
        write_reg(ssjf_pkg::CFG_REF_MV, refmv);
        cfg_we <= 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        cycles    = 0;
        no_idle   = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // power-up settings: feedback extremes, ignored items, ticks not yet due
        send_item(ssjf_pkg::CMD_ADC, 3'd0, 12'd0, 12'd0);
        send_item(ssjf_pkg::CMD_ADC, 3'd0, 12'd0, 12'd4095);
        send_item(ssjf_pkg::CMD_SET, 3'd0, 12'd2700, 12'd0);
        send_item(ssjf_pkg::CMD_ADC, 3'd0, 12'd0, 12'd4095);
        send_item(ssjf_pkg::CMD_ADC, 3'd0, 12'd0, 12'd0);
        send_item(ssjf_pkg::CMD_SET, 3'd0, 12'd4095, 12'd0);
        send_item(ssjf_pkg::CMD_ADC, 3'd0, 12'd0, 12'd2048);
        send_item(ssjf_pkg::CMD_SET, 3'd6, 12'd100, 12'd0);
        send_item(ssjf_pkg::CMD_SET, 3'd7, 12'd100, 12'd0);
        send_item(CMD_SPARE, 3'd7, 12'hFFF, 12'hFFF);
        repeat (3) send_item(ssjf_pkg::CMD_TICK, 3'd0, 12'd0, 12'd0);
        settle();

        // zero interval, equal map angles, targets at the extremes, snapping to target
        write_settings(16'd0, 16'd100, 16'd100, 16'd1234, 16'd5000, 16'd50, 16'd3300);
        send_item(ssjf_pkg::CMD_ADC, 3'd0, 12'd0, 12'd1532);
        send_item(ssjf_pkg::CMD_SET, 3'd1, 12'd0, 12'd0);
        send_item(ssjf_pkg::CMD_SET, 3'd2, 12'd4095, 12'd0);
        send_item(ssjf_pkg::CMD_SET, 3'd3, 12'd801, 12'd0);
        send_item(ssjf_pkg::CMD_SET, 3'd4, 12'd1800, 12'd0);
        send_item(ssjf_pkg::CMD_SET, 3'd5, 12'd4095, 12'd0);
        repeat (3) send_item(ssjf_pkg::CMD_TICK, 3'd0, 12'd0, 12'd0);
        settle();

        write_settings(16'd65535, 16'd0, 16'd270, 16'd0, 16'd3300, 16'd50, 16'd3300);
        repeat (2) send_item(ssjf_pkg::CMD_TICK, 3'd0, 12'd0, 12'd0);
        settle();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_settings(16'd1, 16'd0, 16'd360, 16'd0, 16'd5000, 16'd500, 16'd5000);
                1: write_settings(16'd0, 16'd360, 16'd0, 16'd5000, 16'd0, 16'd0, 16'd0);
                2: write_settings(16'd2, 16'd511, 16'd511, 16'd8191, 16'd8191, 16'd8191,
                                  16'd8191);
                3: write_settings(16'($urandom_range(3)), 16'($urandom_range(511)),
                                  16'($urandom_range(511)), 16'($urandom_range(8191)),
                                  16'($urandom_range(8191)), 16'($urandom_range(1000)),
                                  16'($urandom_range(8191)));
                default: write_settings(16'd3, 16'd0, 16'd270, 16'd0, 16'd3300, 16'd50,
                                        16'd3300);
            endcase
            no_idle = (phase == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 4 && n == ITEMS_PER_PHASE / 2) begin
                    settle();
                end
                send_random();
            end
            settle();
        end
        no_idle = 1'b0;

        if (mismatch_count == 0 && outputs_owed == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ servo_slew_and_joint_feedback_top.f @@
sv/ssjf_pkg.sv
sv/ssjf_ram.sv
sv/ssjf_div.sv
sv/ssjf_feedback.sv
sv/servo_slew_and_joint_feedback_top.sv
tb/sv/servo_feedback_checker.sv
tb/sv/servo_slew_and_joint_feedback_top_tb.sv
